[sv/sars_pkg.sv]
// ----------------------------------------------------------------------------
// sars_pkg
// Shared types and constants for the summed-area range-sum block.
// ----------------------------------------------------------------------------
package sars_pkg;

   localparam int COORD_W   = 8;
   localparam int ELEM_W    = 16;
   localparam int SIDE_CFG_W = 9;
   localparam int SUM_W     = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [ELEM_W-1:0]   element_value;
      logic [COORD_W-1:0]  row_from;
      logic [COORD_W-1:0]  col_from;
      logic [COORD_W-1:0]  row_to;
      logic [COORD_W-1:0]  col_to;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] range_sum;
      logic             bad_query;
   } rsp_type;

   // table read address source
   typedef enum logic [2:0] {
      SEL_ABOVE,
      SEL_A,
      SEL_B,
      SEL_C,
      SEL_D
   } rd_sel_type;

   // accumulator operation on the table read data
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB_ROW,
      ACC_SUB_COL,
      ACC_ADD_CORNER
   } acc_op_type;

   typedef struct packed {
      logic       capture;
      logic       check;
      logic       load_write;
      logic       result_load;
      rd_sel_type rd_sel;
      acc_op_type acc_op;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic out_free;
   } status_type;

endpackage

[sv/sars_ram.sv]
// ----------------------------------------------------------------------------
// sars_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sars_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sars_ctrl.sv]
// ----------------------------------------------------------------------------
// sars_ctrl
// Sequencer for loads (read above, write entry) and queries (four reads).
// ----------------------------------------------------------------------------
module sars_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_stall,
   input  sars_pkg::status_type status,
   output sars_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_READ,
      ST_LD_WRITE,
      ST_Q_CHECK,
      ST_Q_RD_B,
      ST_Q_RD_C,
      ST_Q_RD_D,
      ST_Q_LAST,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = sars_pkg::SEL_A;
      cmd.acc_op      = sars_pkg::ACC_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = (req_operation == sars_pkg::OP_QUERY) ? ST_Q_CHECK : ST_LD_READ;
            end
         end
         ST_LD_READ: begin
            cmd.rd_sel = sars_pkg::SEL_ABOVE;
            state_in   = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            cmd.load_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_Q_CHECK: begin
            cmd.check  = 1'b1;
            cmd.rd_sel = sars_pkg::SEL_A;
            state_in   = status.bad ? ST_RESULT : ST_Q_RD_B;
         end
         ST_Q_RD_B: begin
            cmd.acc_op = sars_pkg::ACC_LOAD;
            cmd.rd_sel = sars_pkg::SEL_B;
            state_in   = ST_Q_RD_C;
         end
         ST_Q_RD_C: begin
            cmd.acc_op = sars_pkg::ACC_SUB_ROW;
            cmd.rd_sel = sars_pkg::SEL_C;
            state_in   = ST_Q_RD_D;
         end
         ST_Q_RD_D: begin
            cmd.acc_op = sars_pkg::ACC_SUB_COL;
            cmd.rd_sel = sars_pkg::SEL_D;
            state_in   = ST_Q_LAST;
         end
         ST_Q_LAST: begin
            cmd.acc_op = sars_pkg::ACC_ADD_CORNER;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // wait for room in the output register
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

[sv/sars_datapath.sv]
// ----------------------------------------------------------------------------
// sars_datapath
// Load position, running row sum, prefix table, query accumulator and the
// result register.
// ----------------------------------------------------------------------------
module sars_datapath #(
   parameter int MAX_SIDE     = 256,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sars_pkg::req_type                    req_payload,
   input  logic                                 csr_write_enable,
   input  logic [sars_pkg::SIDE_CFG_W-1:0]      csr_write_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output sars_pkg::rsp_type                    rsp_payload,
   input  sars_pkg::cmd_type                    cmd,
   output sars_pkg::status_type                 status
);

   localparam int LD_W       = $clog2(MAX_SIDE);
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int EFF_BITS   = (ELEMENT_BITS < sars_pkg::ELEM_W) ? ELEMENT_BITS
                                                                 : sars_pkg::ELEM_W;
   localparam logic [sars_pkg::ELEM_W-1:0] ELEM_MASK =
      sars_pkg::ELEM_W'((64'd1 << EFF_BITS) - 64'd1);
   localparam int RESET_SIDE = (MAX_SIDE < 256) ? MAX_SIDE : 256;

   localparam int SW = sars_pkg::SUM_W;

   function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned r,
                                                   input int unsigned c);
      return ADDR_W'(r * MAX_SIDE + c);
   endfunction

   sars_pkg::req_type     item_ff;
   logic [SIDE_W-1:0]     side_ff, side_in;
   logic [LD_W-1:0]       row_ff, row_in;
   logic [LD_W-1:0]       col_ff, col_in;
   logic [SW-1:0]         run_ff, run_in;
   logic                  complete_ff, complete_in;
   logic                  bad_ff;
   logic [SW-1:0]         acc_ff, acc_in;
   logic                  rsp_valid_ff;
   sars_pkg::rsp_type     rsp_data_ff;

   logic [SW-1:0]         rd_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SW-1:0]         wr_data;
   logic [SW-1:0]         elem;
   logic [SW-1:0]         above;
   logic                  last_col;
   logic                  last_row;
   logic                  bad_now;
   logic [sars_pkg::COORD_W-1:0] rf_m1;
   logic [sars_pkg::COORD_W-1:0] cf_m1;
   logic [LD_W-1:0]       row_m1;
   logic                  rf_nz;
   logic                  cf_nz;

   assign elem   = SW'(item_ff.element_value & ELEM_MASK);
   assign rf_m1  = item_ff.row_from - 1'b1;
   assign cf_m1  = item_ff.col_from - 1'b1;
   assign row_m1 = row_ff - 1'b1;
   assign rf_nz  = (item_ff.row_from != '0);
   assign cf_nz  = (item_ff.col_from != '0);

   assign bad_now = !complete_ff
                 || (item_ff.row_from > item_ff.row_to)
                 || (item_ff.col_from > item_ff.col_to)
                 || (int'(item_ff.row_to) >= int'(side_ff))
                 || (int'(item_ff.col_to) >= int'(side_ff));

   always_comb begin
      case (cmd.rd_sel)
         sars_pkg::SEL_ABOVE: rd_addr = cell_addr(32'(row_m1), 32'(col_ff));
         sars_pkg::SEL_A:     rd_addr = cell_addr(32'(item_ff.row_to), 32'(item_ff.col_to));
         sars_pkg::SEL_B:     rd_addr = cell_addr(32'(rf_m1), 32'(item_ff.col_to));
         sars_pkg::SEL_C:     rd_addr = cell_addr(32'(item_ff.row_to), 32'(cf_m1));
         sars_pkg::SEL_D:     rd_addr = cell_addr(32'(rf_m1), 32'(cf_m1));
         default:             rd_addr = '0;
      endcase
   end

   // load: entry = entry above + running sum of this row
   assign last_col = (int'(col_ff) == int'(side_ff) - 1);
   assign last_row = (int'(row_ff) == int'(side_ff) - 1);
   assign above    = (row_ff == '0) ? '0 : rd_data;
   assign wr_addr  = cell_addr(32'(row_ff), 32'(col_ff));
   assign wr_data  = above + run_in;

   always_comb begin
      run_in      = ((col_ff == '0) ? '0 : run_ff) + elem;
      side_in     = side_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      complete_in = complete_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            side_in = SIDE_W'(1);
         end else if (int'(csr_write_data) > MAX_SIDE) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(csr_write_data);
         end
         row_in      = '0;
         col_in      = '0;
         complete_in = 1'b0;
      end else if (cmd.load_write) begin
         complete_in = 1'b0;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in      = '0;
               complete_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      case (cmd.acc_op)
         sars_pkg::ACC_HOLD:       acc_in = acc_ff;
         sars_pkg::ACC_LOAD:       acc_in = rd_data;
         sars_pkg::ACC_SUB_ROW:    acc_in = rf_nz ? acc_ff - rd_data : acc_ff;
         sars_pkg::ACC_SUB_COL:    acc_in = cf_nz ? acc_ff - rd_data : acc_ff;
         sars_pkg::ACC_ADD_CORNER: acc_in = (rf_nz && cf_nz) ? acc_ff + rd_data : acc_ff;
         default:                  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SIDE_W'(RESET_SIDE);
         row_ff       <= '0;
         col_ff       <= '0;
         run_ff       <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff     <= side_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         complete_ff <= complete_in;
         if (csr_write_enable) begin
            run_ff <= '0;
         end else if (cmd.load_write) begin
            run_ff <= run_in;
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.check) begin
         bad_ff <= bad_now;
      end
      acc_ff <= acc_in;
      if (cmd.result_load) begin
         rsp_data_ff.range_sum <= bad_ff ? '0 : acc_ff;
         rsp_data_ff.bad_query <= bad_ff;
      end
   end

   sars_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.bad      = bad_now;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_data_ff;

endmodule

[sv/summed_area_range_sum.sv]
// ----------------------------------------------------------------------------
// summed_area_range_sum
// Summed-area table builder with inclusive rectangle sum queries.
// ----------------------------------------------------------------------------
// Input channel (req_): a load transaction brings the next grid element in
// row-major order; a query transaction names an inclusive rectangle. Loads
// give no result; each query gives one rsp_ transaction with the sum, or
// bad_query set and a zero sum.
// One transaction is in work at a time. A load reads the entry above through
// the table RAM's registered port, then writes the entry. A query makes four
// corner reads on the single RAM read port plus the accumulate, then the
// result register load; a rejected query goes from the check straight to the
// result register load. With the output register free, that load raises
// rsp_valid. req_stall is high from the cycle after acceptance until free.
// The result sits in an output register; while rsp_stall holds it there the
// block still takes the next transaction, and a later query waits at its end
// until the register is free.
// csr_write_data sets the grid side (0 acts as 1, above MAX_SIDE as MAX_SIDE)
// and restarts loading; write it only while the block is idle.
// Reset: side = 256 (capped at MAX_SIDE), loading at row 0 and column 0, table
// marked incomplete, output empty. The table RAM is not cleared.
// ----------------------------------------------------------------------------
module summed_area_range_sum #(
   parameter int MAX_SIDE     = 256,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sars_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sars_pkg::rsp_type               rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [sars_pkg::SIDE_CFG_W-1:0] csr_write_data
);

   sars_pkg::cmd_type    cmd;
   sars_pkg::status_type status;

   sars_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_payload.operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   sars_datapath #(
      .MAX_SIDE     (MAX_SIDE),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

[sv/sars_checker.sv]
// ----------------------------------------------------------------------------
// sars_checker
// Port-level checks for summed_area_range_sum, bound to the top level.
// ----------------------------------------------------------------------------
module sars_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input sars_pkg::req_type               req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input sars_pkg::rsp_type               rsp_payload
);

   logic req_accept;
   assign req_accept = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.bad_query || rsp_payload.range_sum == '0))
      else $error("rejected query carries a nonzero sum");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("new transaction taken while one is in work");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a transaction in work");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_payload.operation == sars_pkg::OP_LOAD)
         |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("load produced a result");

endmodule

bind summed_area_range_sum sars_checker u_sars_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_payload      (req_payload),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload      (rsp_payload)
);
